### hw/rtl/rdpal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpal_pkg
// Shared constants and types of the palette port: register offsets, pointer
// and location widths, and the access descriptor passed to the store side.
// ----------------------------------------------------------------------------
package rdpal_pkg;

  // register offsets on the host bus
  localparam logic [3:0] OFF_PTR_LO = 4'h0;
  localparam logic [3:0] OFF_PTR_HI = 4'h4;
  localparam logic [3:0] OFF_ENTRY  = 4'h8;
  localparam logic [3:0] OFF_COMP   = 4'hC;

  // pointer, component and byte location widths
  localparam int unsigned PTR_W  = 12;
  localparam int unsigned COMP_W = 2;
  localparam int unsigned LOC_W  = 14;

  // index of the last colour component of an entry
  localparam logic [COMP_W-1:0] COMP_LAST = 2'd2;

  // entries at which an entry access also steps the component
  localparam logic [PTR_W-1:0] PTR_STEP_A = 12'h100;
  localparam logic [PTR_W-1:0] PTR_STEP_B = 12'h101;

  // one decoded request as seen by the store side
  typedef struct packed {
    logic             mem_op;   // request touches the store
    logic             wr;       // write request
    logic [LOC_W-1:0] loc;      // byte location in the store
    logic [7:0]       imm;      // register read value
  } acc_t;

endpackage

### hw/rtl/rdpal_ptr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpal_ptr
// Entry pointer and component index with auto-increment. Decodes each
// accepted request into a store location or a register read value.
// ----------------------------------------------------------------------------
module rdpal_ptr
  import rdpal_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic       action_i,
  input  logic [3:0] bus_offset_i,
  input  logic [7:0] write_data_i,
  output acc_t       acc_o
);

  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [COMP_W-1:0] comp_q, comp_d;
  logic              step;
  logic [LOC_W-1:0]  base;

  // byte location of component 0: pointer times three
  assign base = {1'b0, ptr_q, 1'b0} + {2'b00, ptr_q};

  // request decode
  always_comb begin
    acc_o.mem_op = 1'b0;
    acc_o.wr     = action_i;
    acc_o.loc    = base;
    acc_o.imm    = '0;
    step         = 1'b0;
    ptr_d        = ptr_q;
    comp_d       = comp_q;
    unique case (bus_offset_i)
      OFF_PTR_LO: begin
        if (action_i) begin
          ptr_d  = {ptr_q[PTR_W-1:8], write_data_i};
          comp_d = '0;
        end else begin
          acc_o.imm = ptr_q[7:0];
        end
      end
      OFF_PTR_HI: begin
        if (action_i) begin
          ptr_d  = {write_data_i[3:0], ptr_q[7:0]};
          comp_d = '0;
        end else begin
          acc_o.imm = {4'b0000, ptr_q[PTR_W-1:8]};
        end
      end
      OFF_ENTRY: begin
        acc_o.mem_op = 1'b1;
        step         = (ptr_q == PTR_STEP_A) || (ptr_q == PTR_STEP_B);
      end
      OFF_COMP: begin
        acc_o.mem_op = 1'b1;
        acc_o.loc    = base + {{(LOC_W-COMP_W){1'b0}}, comp_q};
        step         = 1'b1;
      end
      default: ;
    endcase
    // component step, advancing the pointer after the last one
    if (step) begin
      if (comp_q == COMP_LAST) begin
        comp_d = '0;
        ptr_d  = ptr_q + 1'b1;
      end else begin
        comp_d = comp_q + 1'b1;
      end
    end
  end

  // pointer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      comp_q <= '0;
    end else if (take_i) begin
      ptr_q  <= ptr_d;
      comp_q <= comp_d;
    end
  end

  // component index stays within the three colours
  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_q != 2'd3)
    else $error("component index out of range");

  // a pointer write restarts at component 0
  a_ptr_wr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && action_i && (bus_offset_i == OFF_PTR_LO || bus_offset_i == OFF_PTR_HI))
    |=> comp_q == '0)
    else $error("pointer write did not clear component");

  // stepping past the last component of the last entry wraps the pointer
  a_ptr_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && bus_offset_i == OFF_COMP && comp_q == COMP_LAST && ptr_q == '1)
    |=> ptr_q == '0 && comp_q == '0)
    else $error("pointer did not wrap");

endmodule

### hw/rtl/ramdac_palette_port_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramdac_palette_port_core
// Byte-wide palette port of a video DAC with auto-incrementing entry pointer.
// ----------------------------------------------------------------------------
// One request is taken per clock while in_stall_o is low. Its read byte is
// held in the request stage, with the registered read of the single-port
// palette memory, and then in the result register, which drives read_data_o;
// a stall on out_stall_i holds it there. After reset the palette memory is
// swept to zero, one byte per cycle, over all STORE_BYTES locations, and
// in_stall_o stays high until the sweep ends. Every request, read or write,
// returns exactly one byte; writes and unused offsets return zero.
module ramdac_palette_port_core
  import rdpal_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [3:0] bus_offset_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);

  acc_t              acc;
  logic              take;
  logic              in_range;
  logic [ADDR_W-1:0] mem_addr;
  logic              s1_adv;

  logic              clr_active_q;
  logic [ADDR_W-1:0] clr_addr_q;

  logic              s1_valid_q;
  logic              s1_sel_mem_q;
  logic [7:0]        s1_imm_q;
  logic [7:0]        rdata_q;

  logic              out_valid_q;
  logic [7:0]        out_data_q;

  logic [7:0]        mem [STORE_BYTES];

  // pointer and decode
  rdpal_ptr u_ptr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .action_i     (action_i),
    .bus_offset_i (bus_offset_i),
    .write_data_i (write_data_i),
    .acc_o        (acc)
  );

  // request handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_adv);
  assign take       = in_valid_i && !in_stall_o;

  // location check against the store size
  assign in_range = {1'b0, acc.loc} < (LOC_W + 1)'(STORE_BYTES);
  assign mem_addr = acc.loc[ADDR_W-1:0];

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (clr_addr_q == ADDR_W'(STORE_BYTES - 1)) begin
        clr_active_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // palette memory with registered read
  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      mem[clr_addr_q] <= '0;
    end else if (take && acc.mem_op && acc.wr && in_range) begin
      mem[mem_addr] <= write_data_i;
    end
    if (take && acc.mem_op && !acc.wr && in_range) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // request stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // request stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_sel_mem_q <= acc.mem_op && !acc.wr && in_range;
      s1_imm_q     <= acc.imm;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= s1_sel_mem_q ? rdata_q : s1_imm_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  // no request is taken during the clearing sweep
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !take)
    else $error("request taken during clearing sweep");

  // a taken request always occupies the request stage next cycle
  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> s1_valid_q)
    else $error("taken request lost");

  // a stage advance always leaves a result waiting
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced request produced no result");

endmodule
